[sv/matrix_alu_4x4_macros.svh]
// Assertion macros shared by the matrix ALU checker.
`ifndef MATRIX_ALU_4X4_MACROS_SVH
`define MATRIX_ALU_4X4_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define MA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/malu_pkg.sv]
// Package with types, codes and arithmetic helpers of the matrix ALU.
`timescale 1ns / 1ps
`default_nettype none
package malu_pkg;
    localparam int DIM = 4;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W = 2;
    localparam int NELEM = DIM * DIM;
    localparam int EL_W = 4;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_TRANS = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic signed [31:0] value;
        logic [2:0] op;
    } cmd_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v,
                                                 output logic hit);
        begin
            hit = 1'b0;
            if (v > 64'sd2147483647) begin
                hit = 1'b1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648) begin
                hit = 1'b1;
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

[sv/malu_front.sv]
// Front end: accepts beats, drops meaningless ones and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module malu_front import malu_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [1:0] s_row_index,
    input  wire logic [1:0] s_col_index,
    input  wire logic signed [31:0] s_operand_value,
    input  wire logic [2:0] s_op_code,
    output logic q_valid,
    input  wire logic q_ready,
    output cmd_t q_cmd
);
    cmd_t q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0] cnt_reg;
    logic keep, push, pop;

    assign s_ready = (cnt_reg != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
    assign keep = (s_req_type == REQ_LOAD_A) || (s_req_type == REQ_LOAD_B) ||
                  ((s_req_type == REQ_COMPUTE) && (s_op_code <= OP_TRANS));
    assign push = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_cmd = q_mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_reg] <= '{kind: s_req_type, row: s_row_index, col: s_col_index,
                                   value: s_operand_value, op: s_op_code};
        end
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[sv/malu_back.sv]
// Back end: holds A and B and sequences each operation element by element.
`timescale 1ns / 1ps
`default_nettype none
module malu_back import malu_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output logic m_valid,
    input  wire logic m_ready,
    output logic [1:0] m_out_row,
    output logic [1:0] m_out_col,
    output logic signed [31:0] m_out_value,
    output logic [1:0] m_status,
    output logic m_last
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MULT = 5'b00010, S_DIV = 5'b00100,
        S_FIN = 5'b01000, S_EMIT = 5'b10000
    } state_t;

    logic signed [31:0] a_reg [NELEM];
    logic signed [31:0] b_reg [NELEM];
    state_t state_reg;
    cmd_t cmd_reg;
    logic [IDX_W-1:0] r_reg, c_reg, k_reg;
    logic signed [65:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic pv_reg;
    logic [63:0] rem_reg, quo_reg, dvd_reg;
    logic [31:0] dvs_reg;
    logic [6:0] bit_reg;
    logic signed [31:0] val_reg;
    logic [1:0] st_reg;
    logic signed [31:0] ea, eb, ta, ma, mb;
    logic signed [63:0] rs;
    logic [63:0] trial;
    logic [64:0] rem_sh;
    logic signed [63:0] qs;
    logic last_el;
    logic signed [65:0] dot_sum, dot_shr;
    logic signed [31:0] fin_val, mul_val, div_val;
    logic fin_hit, mul_hit, div_hit;

    assign ea = a_reg[{r_reg, c_reg}];
    assign eb = b_reg[{r_reg, c_reg}];
    assign ta = a_reg[{c_reg, r_reg}];
    assign ma = a_reg[{r_reg, k_reg}];
    assign mb = b_reg[{k_reg, c_reg}];
    assign q_ready = (state_reg == S_IDLE);
    assign last_el = (r_reg == IDX_W'(DIM-1)) && (c_reg == IDX_W'(DIM-1));
    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign trial = rem_sh[63:0] - {32'd0, dvs_reg};
    assign qs = quo_reg;
    assign dot_sum = acc_reg + 66'(prod_reg);
    assign dot_shr = dot_sum >>> FRAC_BITS;

    always_comb begin
        rs = '0;
        case (cmd_reg.op)
            OP_ADD: rs = 64'(ea) + 64'(eb);
            OP_SUB: rs = 64'(ea) - 64'(eb);
            OP_SCALE: rs = (64'(ea) * 64'(cmd_reg.value)) >>> FRAC_BITS;
            default: rs = 64'(ta);
        endcase
        fin_val = sat64(rs, fin_hit);
        mul_val = sat64(64'(dot_shr), mul_hit);
        if (ea[31] ^ cmd_reg.value[31]) begin
            div_val = sat64(-qs, div_hit);
        end else begin
            div_val = sat64(qs, div_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid <= 1'b0;
            for (int i = 0; i < NELEM; i++) begin
                a_reg[i] <= '0;
                b_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg <= q_cmd;
                        r_reg <= '0;
                        c_reg <= '0;
                        if (q_cmd.kind == REQ_LOAD_A) begin
                            a_reg[{q_cmd.row, q_cmd.col}] <= q_cmd.value;
                        end else if (q_cmd.kind == REQ_LOAD_B) begin
                            b_reg[{q_cmd.row, q_cmd.col}] <= q_cmd.value;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b0;
                        if (cmd_reg.op == OP_MUL) begin
                            k_reg <= '0;
                            acc_reg <= '0;
                            pv_reg <= 1'b0;
                            state_reg <= S_MULT;
                        end else if (cmd_reg.op == OP_DIV) begin
                            if (cmd_reg.value == 0) begin
                                val_reg <= '0;
                                st_reg <= ST_DIVZ;
                                state_reg <= S_EMIT;
                            end else begin
                                dvd_reg <= ea[31] ? 64'(-(64'(ea) <<< FRAC_BITS))
                                                  : 64'(64'(ea) <<< FRAC_BITS);
                                dvs_reg <= cmd_reg.value[31] ? 32'(-cmd_reg.value)
                                                             : cmd_reg.value;
                                rem_reg <= '0;
                                quo_reg <= '0;
                                bit_reg <= 7'd64;
                                state_reg <= S_DIV;
                            end
                        end else begin
                            val_reg <= fin_val;
                            st_reg <= (cmd_reg.op == OP_TRANS) ? ST_OK
                                                               : (fin_hit ? ST_SAT : ST_OK);
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_MULT: begin
                    prod_reg <= 64'(ma) * 64'(mb);
                    pv_reg <= 1'b1;
                    if (pv_reg) acc_reg <= dot_sum;
                    k_reg <= k_reg + 1'b1;
                    if (pv_reg && k_reg == '0) begin
                        val_reg <= mul_val;
                        st_reg <= mul_hit ? ST_SAT : ST_OK;
                        state_reg <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (bit_reg == '0) begin
                        val_reg <= div_val;
                        st_reg <= div_hit ? ST_SAT : ST_OK;
                        state_reg <= S_EMIT;
                    end else begin
                        dvd_reg <= dvd_reg << 1;
                        bit_reg <= bit_reg - 1'b1;
                        if (!rem_sh[64] && rem_sh[63:0] < {32'd0, dvs_reg}) begin
                            rem_reg <= rem_sh[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end else begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                    end
                end
                S_EMIT: begin
                    m_valid <= 1'b1;
                    m_out_row <= r_reg;
                    m_out_col <= c_reg;
                    m_out_value <= val_reg;
                    m_status <= st_reg;
                    m_last <= last_el;
                    if (last_el) begin
                        state_reg <= S_IDLE;
                    end else begin
                        if (c_reg == IDX_W'(DIM-1)) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 1'b1;
                        end else begin
                            c_reg <= c_reg + 1'b1;
                        end
                        state_reg <= S_FIN;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg != S_EMIT && state_reg != S_FIN && m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[sv/matrix_alu_4x4.sv]
// Top level of the fixed-point 4x4 matrix ALU.
// Load beats write one element of A or B.
// A compute beat is dispatched and then emits sixteen result beats in row-major
// order with last on the final one; multiply uses one shared 32x32 multiplier
// over four products with a registered product, and divide uses a bit-serial
// restoring divider of 64 steps with setup before and sign fix and output after.
// A four-entry command queue lets loads be taken while the back end works.
`timescale 1ns / 1ps
`default_nettype none
module matrix_alu_4x4 import malu_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [1:0] s_row_index,
    input  wire logic [1:0] s_col_index,
    input  wire logic signed [31:0] s_operand_value,
    input  wire logic [2:0] s_op_code,
    output logic m_valid,
    input  wire logic m_ready,
    output logic [1:0] m_out_row,
    output logic [1:0] m_out_col,
    output logic signed [31:0] m_out_value,
    output logic [1:0] m_status,
    output logic m_last
);
    logic q_valid, q_ready;
    cmd_t q_cmd;

    malu_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_row_index,
        .s_col_index, .s_operand_value, .s_op_code, .q_valid, .q_ready, .q_cmd
    );

    malu_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .m_valid, .m_ready,
        .m_out_row, .m_out_col, .m_out_value, .m_status, .m_last
    );
endmodule
`default_nettype wire

[sv/malu_checker.sv]
// Port-level checker for the matrix ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_alu_4x4_macros.svh"
module malu_checker import malu_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [1:0] m_out_row,
    input wire logic [1:0] m_out_col,
    input wire logic signed [31:0] m_out_value,
    input wire logic [1:0] m_status,
    input wire logic m_last
);
    `MA_ASSERT_IMP(a_last_pos, aclk, aresetn, m_valid && m_last, (m_out_row == 2'd3) && (m_out_col == 2'd3), "last beat is not the final element")
    `MA_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status != 2'd3, "undefined status code")
    `MA_ASSERT_IMP(a_divz_zero, aclk, aresetn, m_valid && (m_status == ST_DIVZ), m_out_value == 32'sd0, "divide by zero beat is not zero")
    `MA_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_value), "stalled result beat changed")
endmodule
bind matrix_alu_4x4 malu_checker u_malu_checker (.*);
`default_nettype wire

[tb/sv/matrix_alu_4x4_tb.sv]
// Self-checking testbench for the 4x4 fixed-point matrix ALU.
`timescale 1ns / 1ps
`default_nettype none

class matrix_alu_scoreboard;
    logic signed [31:0] mat_a [16];
    logic signed [31:0] mat_b [16];
    logic [1:0]         exp_row [$];
    logic [1:0]         exp_col [$];
    logic signed [31:0] exp_value [$];
    logic [1:0]         exp_status [$];
    logic               exp_last [$];
    int                 errors;

    function new();
        foreach (mat_a[i]) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        errors = 0;
    endfunction

    function int pending();
        return exp_value.size();
    endfunction

    function logic signed [31:0] clamp(input logic signed [127:0] v, inout logic hit);
        if (v > 128'sd2147483647) begin
            hit = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function void note_beat(input logic [1:0] req, input logic [1:0] row,
                            input logic [1:0] col, input logic signed [31:0] opv,
                            input logic [2:0] op);
        logic signed [127:0] acc;
        logic signed [31:0]  v;
        logic [1:0]          st;
        logic                hit;
        if (req == malu_pkg::REQ_LOAD_A) begin
            mat_a[row * 4 + col] = opv;
            return;
        end
        if (req == malu_pkg::REQ_LOAD_B) begin
            mat_b[row * 4 + col] = opv;
            return;
        end
        if (req != malu_pkg::REQ_COMPUTE || op > malu_pkg::OP_TRANS) return;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                hit = 1'b0;
                st = malu_pkg::ST_OK;
                v = '0;
                case (op)
                    malu_pkg::OP_ADD: begin
                        acc = 128'(mat_a[r*4+c]) + 128'(mat_b[r*4+c]);
                        v = clamp(acc, hit);
                    end
                    malu_pkg::OP_SUB: begin
                        acc = 128'(mat_a[r*4+c]) - 128'(mat_b[r*4+c]);
                        v = clamp(acc, hit);
                    end
                    malu_pkg::OP_MUL: begin
                        acc = '0;
                        for (int k = 0; k < 4; k++)
                            acc += 128'(mat_a[r*4+k]) * 128'(mat_b[k*4+c]);
                        v = clamp(acc >>> malu_pkg::FRAC_BITS, hit);
                    end
                    malu_pkg::OP_SCALE: begin
                        acc = 128'(mat_a[r*4+c]) * 128'(opv);
                        v = clamp(acc >>> malu_pkg::FRAC_BITS, hit);
                    end
                    malu_pkg::OP_DIV: begin
                        if (opv == 0) begin
                            st = malu_pkg::ST_DIVZ;
                        end else begin
                            acc = (128'(mat_a[r*4+c]) <<< malu_pkg::FRAC_BITS) / 128'(opv);
                            v = clamp(acc, hit);
                        end
                    end
                    default: v = mat_a[c*4+r];
                endcase
                if (hit) st = malu_pkg::ST_SAT;
                exp_row.push_back(2'(r));
                exp_col.push_back(2'(c));
                exp_value.push_back(v);
                exp_status.push_back(st);
                exp_last.push_back(r == 3 && c == 3);
            end
        end
    endfunction

    function void check_beat(input logic [1:0] row, input logic [1:0] col,
                             input logic signed [31:0] value, input logic [1:0] status,
                             input logic last);
        if (exp_value.size() == 0) begin
            $display("%0t: unexpected result beat row %0d col %0d value %h",
                     $realtime, row, col, value);
            errors++;
            return;
        end
        if (row !== exp_row[0]) begin
            $display("%0t: row expected %0d actual %0d", $realtime, exp_row[0], row);
            errors++;
        end
        if (col !== exp_col[0]) begin
            $display("%0t: col expected %0d actual %0d", $realtime, exp_col[0], col);
            errors++;
        end
        if (value !== exp_value[0]) begin
            $display("%0t: value expected %h actual %h", $realtime, exp_value[0], value);
            errors++;
        end
        if (status !== exp_status[0]) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_status[0],
                     status);
            errors++;
        end
        if (last !== exp_last[0]) begin
            $display("%0t: last expected %0d actual %0d", $realtime, exp_last[0], last);
            errors++;
        end
        void'(exp_row.pop_front());
        void'(exp_col.pop_front());
        void'(exp_value.pop_front());
        void'(exp_status.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module matrix_alu_4x4_tb;
    import malu_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = '0;
    logic [1:0]         s_row_index = '0;
    logic [1:0]         s_col_index = '0;
    logic signed [31:0] s_operand_value = '0;
    logic [2:0]         s_op_code = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_out_row;
    logic [1:0]         m_out_col;
    logic signed [31:0] m_out_value;
    logic [1:0]         m_status;
    logic               m_last;

    matrix_alu_scoreboard sb = new();
    bit  calm = 1'b0;
    int  quiet_cycles = 0;

    matrix_alu_4x4 u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_row_index(s_row_index),
        .s_col_index(s_col_index), .s_operand_value(s_operand_value),
        .s_op_code(s_op_code),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_row(m_out_row), .m_out_col(m_out_col), .m_out_value(m_out_value),
        .m_status(m_status), .m_last(m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_beat(s_req_type, s_row_index, s_col_index, s_operand_value,
                             s_op_code);
            if (m_valid && m_ready)
                sb.check_beat(m_out_row, m_out_col, m_out_value, m_status, m_last);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // The result side stalls in random bursts while calm is not set.
    initial begin
        int n;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge aclk);
        end
    end

    task automatic send_beat(input logic [1:0] req, input logic [1:0] row,
                             input logic [1:0] col, input logic signed [31:0] opv,
                             input logic [2:0] op);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_row_index <= row;
        s_col_index <= col;
        s_operand_value <= opv;
        s_op_code <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
            3: return 32'sh00010000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic load_matrices(input bit extreme);
        for (int i = 0; i < 16; i++) begin
            send_beat(REQ_LOAD_A, 2'(i / 4), 2'(i % 4),
                      extreme ? ((i % 2) ? 32'sh7fffffff : 32'sh80000000) : rand_value(),
                      3'($urandom()));
            send_beat(REQ_LOAD_B, 2'(i / 4), 2'(i % 4),
                      extreme ? ((i % 3) ? 32'sh7fffffff : 32'sh80000000) : rand_value(),
                      3'($urandom()));
        end
    endtask

    initial begin
        logic [2:0] op;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every operation on the reset state and on extreme matrices.
        for (int k = 0; k <= 7; k++) send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sd0, 3'(k));
        send_beat(2'd3, 2'd3, 2'd3, 32'sh7fffffff, OP_ADD);
        load_matrices(1'b1);
        send_beat(REQ_COMPUTE, 2'd3, 2'd3, 32'sh7fffffff, OP_ADD);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sh80000000, OP_SUB);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sd0, OP_MUL);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sh7fffffff, OP_SCALE);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sh80000000, OP_SCALE);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sd0, OP_DIV);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sd1, OP_DIV);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, -32'sd1, OP_DIV);
        send_beat(REQ_COMPUTE, 2'd0, 2'd0, 32'sh80000000, OP_TRANS);

        // The sender holds off until every result has arrived.
        drain();

        // Random: a mix of loads with random content, computes and beats that are dropped.
        for (int i = 0; i < 100; i++) begin
            if (i == 80) calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_beat(REQ_LOAD_A, 2'($urandom()), 2'($urandom()),
                                      rand_value(), 3'($urandom()));
                4, 5, 6, 7: send_beat(REQ_LOAD_B, 2'($urandom()), 2'($urandom()),
                                      rand_value(), 3'($urandom()));
                8: begin
                    op = 3'($urandom_range(0, 5));
                    send_beat(REQ_COMPUTE, 2'($urandom()), 2'($urandom()),
                              ($urandom_range(0, 7) == 0) ? 32'sd0 : rand_value(), op);
                end
                default: send_beat(2'($urandom_range(2, 3)), 2'($urandom()),
                                   2'($urandom()), rand_value(), 3'($urandom_range(6, 7)));
            endcase
        end
        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
